### rtl/joystick_response_curve_macros.svh
// ----------------------------------------------------------------------------
// Joystick response curve assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the synchronous reset is active.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_RESPONSE_CURVE_MACROS_SVH
`define JOYSTICK_RESPONSE_CURVE_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define JRC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define JRC_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### rtl/jrc_pkg.sv
// ----------------------------------------------------------------------------
// Joystick response curve package
// Widths, register map, reset values and shared types.
// ----------------------------------------------------------------------------
package jrc_pkg;

  localparam int AXIS_W     = 16;
  localparam int MAG_W      = AXIS_W + 1;
  localparam int COEF_W     = 16;
  localparam int DB_W       = 15;
  localparam int ACC_W      = 20;
  localparam int PROD_W     = ACC_W + MAG_W + 1;
  localparam int FRAC_SHIFT = 15;
  localparam int NUM_STEPS  = 4;
  localparam int Y_W        = ACC_W + 3;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(16384);
  localparam logic signed [Y_W-1:0]    Y_MAX      = Y_W'(32767);
  localparam logic signed [Y_W-1:0]    Y_MIN      = -Y_W'(32768);
  localparam logic signed [AXIS_W-1:0] OUT_MAX    = 16'sh7fff;
  localparam logic signed [AXIS_W-1:0] OUT_MIN    = 16'sh8000;

  localparam logic [2:0] REG_QUARTIC  = 3'd0;
  localparam logic [2:0] REG_CUBIC    = 3'd1;
  localparam logic [2:0] REG_SQUARE   = 3'd2;
  localparam logic [2:0] REG_LINEAR   = 3'd3;
  localparam logic [2:0] REG_OFFSET   = 3'd4;
  localparam logic [2:0] REG_DEADBAND = 3'd5;

  localparam logic signed [COEF_W-1:0] RST_QUARTIC  = 16'sd18639;
  localparam logic signed [COEF_W-1:0] RST_CUBIC    = -16'sd24479;
  localparam logic signed [COEF_W-1:0] RST_SQUARE   = 16'sd10607;
  localparam logic signed [COEF_W-1:0] RST_LINEAR   = -16'sd356;
  localparam logic signed [COEF_W-1:0] RST_OFFSET   = 16'sd374;
  localparam logic [DB_W-1:0]          RST_DEADBAND = 15'd328;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef struct packed {
    coef_t                       quartic;
    coef_t [NUM_STEPS-1:0]       step_coef;
    logic [DB_W-1:0]             deadband;
  } cfg_t;

  typedef struct packed {
    logic             neg;
    logic             dead;
    logic [MAG_W-1:0] mag;
  } sample_t;

  typedef struct packed {
    logic    valid;
    sample_t smp;
    acc_t    acc;
  } horner_t;

endpackage

### rtl/jrc_cfg.sv
// ----------------------------------------------------------------------------
// Joystick response curve configuration registers
// APB-style register file holding the five coefficients and the deadband.
// ----------------------------------------------------------------------------
module jrc_cfg import jrc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  coef_t           quartic_r, cubic_r, square_r, linear_r, offset_r;
  logic [DB_W-1:0] deadband_r;
  logic            wr_en;
  logic [2:0]      idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quartic_r  <= RST_QUARTIC;
      cubic_r    <= RST_CUBIC;
      square_r   <= RST_SQUARE;
      linear_r   <= RST_LINEAR;
      offset_r   <= RST_OFFSET;
      deadband_r <= RST_DEADBAND;
    end else if (wr_en) begin
      case (idx)
        REG_QUARTIC:  quartic_r  <= pwdata[COEF_W-1:0];
        REG_CUBIC:    cubic_r    <= pwdata[COEF_W-1:0];
        REG_SQUARE:   square_r   <= pwdata[COEF_W-1:0];
        REG_LINEAR:   linear_r   <= pwdata[COEF_W-1:0];
        REG_OFFSET:   offset_r   <= pwdata[COEF_W-1:0];
        REG_DEADBAND: deadband_r <= pwdata[DB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_QUARTIC:  prdata = CFG_DATA_W'(quartic_r);
      REG_CUBIC:    prdata = CFG_DATA_W'(cubic_r);
      REG_SQUARE:   prdata = CFG_DATA_W'(square_r);
      REG_LINEAR:   prdata = CFG_DATA_W'(linear_r);
      REG_OFFSET:   prdata = CFG_DATA_W'(offset_r);
      REG_DEADBAND: prdata = {{(CFG_DATA_W-DB_W){1'b0}}, deadband_r};
      default:      prdata = '0;
    endcase
  end

  assign cfg.quartic   = quartic_r;
  assign cfg.step_coef = {offset_r, linear_r, square_r, cubic_r};
  assign cfg.deadband  = deadband_r;

endmodule

### rtl/jrc_front.sv
// ----------------------------------------------------------------------------
// Joystick response curve front end
// Accepts axis samples, splits them into sign and magnitude, flags the
// deadband and holds them in a two-entry queue for the evaluation pipeline.
// ----------------------------------------------------------------------------
module jrc_front import jrc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [AXIS_W-1:0] axis_value,
  input  logic [DB_W-1:0]   deadband,
  output logic              busy,
  output logic              q_valid,
  output sample_t           q_item
);

  sample_t    mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r, count_nxt;
  logic       push, pop;
  sample_t    smp;

  always_comb begin
    smp.neg  = axis_value[AXIS_W-1];
    smp.mag  = smp.neg ? (MAG_W'(0) - {axis_value[AXIS_W-1], axis_value})
                       : {1'b0, axis_value};
    smp.dead = smp.mag < {{(MAG_W-DB_W){1'b0}}, deadband};
  end

  assign busy    = (count_r == 2'd2);
  assign push    = start & ~busy;
  assign q_valid = (count_r != 2'd0);
  assign pop     = q_valid;
  assign q_item  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= smp;
    end
  end

endmodule

### rtl/jrc_horner_step.sv
// ----------------------------------------------------------------------------
// Joystick response curve Horner step
// One Horner iteration in two stages: multiply the accumulator by the
// magnitude, then round, rescale and add the next coefficient.
// ----------------------------------------------------------------------------
module jrc_horner_step import jrc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  horner_t h_in,
  input  coef_t   coef,
  output horner_t h_out
);

  logic                     s1_valid_r;
  sample_t                  s1_smp_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [PROD_W-1:0] rsum, shifted;
  logic                     s2_valid_r;
  sample_t                  s2_smp_r;
  acc_t                     acc_r, acc_nxt;

  assign prod_nxt = h_in.acc * $signed({1'b0, h_in.smp.mag});
  assign rsum     = prod_r + ROUND_HALF;
  assign shifted  = rsum >>> FRAC_SHIFT;
  assign acc_nxt  = $signed(shifted[ACC_W-1:0]) + ACC_W'(coef);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= h_in.valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_smp_r <= h_in.smp;
    prod_r   <= prod_nxt;
    s2_smp_r <= s1_smp_r;
    acc_r    <= acc_nxt;
  end

  assign h_out.valid = s2_valid_r;
  assign h_out.smp   = s2_smp_r;
  assign h_out.acc   = acc_r;

endmodule

### rtl/jrc_back.sv
// ----------------------------------------------------------------------------
// Joystick response curve back end
// Evaluates the quartic by a chain of Horner steps, restores the sign,
// zeroes deadband samples, saturates to Q1.15 and registers the result.
// ----------------------------------------------------------------------------
module jrc_back import jrc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  sample_t           q_item,
  input  cfg_t              cfg,
  output logic              out_valid,
  output logic [AXIS_W-1:0] out_drive_value,
  output logic              out_clamped
);

  horner_t                chain [NUM_STEPS+1];
  logic signed [Y_W-1:0]  y_abs, y_sgn;
  logic [AXIS_W-1:0]      drive_nxt;
  logic                   clamp_nxt;
  logic                   valid_r;
  logic [AXIS_W-1:0]      drive_r;
  logic                   clamp_r;
  horner_t                last;

  assign chain[0].valid = q_valid;
  assign chain[0].smp   = q_item;
  assign chain[0].acc   = ACC_W'(cfg.quartic);

  for (genvar i = 0; i < NUM_STEPS; i++) begin : g_step
    jrc_horner_step u_step (
      .clk   (clk),
      .rst_n (rst_n),
      .h_in  (chain[i]),
      .coef  (cfg.step_coef[i]),
      .h_out (chain[i+1])
    );
  end

  assign last  = chain[NUM_STEPS];
  assign y_abs = {last.acc, 3'b000};
  assign y_sgn = last.smp.neg ? -y_abs : y_abs;

  always_comb begin
    if (last.smp.dead) begin
      drive_nxt = '0;
      clamp_nxt = 1'b0;
    end else if (y_sgn > Y_MAX) begin
      drive_nxt = OUT_MAX;
      clamp_nxt = 1'b1;
    end else if (y_sgn < Y_MIN) begin
      drive_nxt = OUT_MIN;
      clamp_nxt = 1'b1;
    end else begin
      drive_nxt = y_sgn[AXIS_W-1:0];
      clamp_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    drive_r <= drive_nxt;
    clamp_r <= clamp_nxt;
  end

  assign out_valid       = valid_r;
  assign out_drive_value = drive_r;
  assign out_clamped     = clamp_r;

endmodule

### rtl/joystick_response_curve.sv
// ----------------------------------------------------------------------------
// Joystick response curve
// Shapes a Q1.15 joystick axis sample into a saturated Q1.15 drive value
// through a deadband and a programmable quartic with Q4.12 coefficients.
// ----------------------------------------------------------------------------
// The block accepts one sample per clock while busy is low and registers each
// result through the input queue, four two-stage Horner steps and the output
// register. The result is shown for one cycle with out_valid high and must be
// captured then. The user writes coefficients and the deadband over the
// APB-style port only while no sample is in flight, not enforced by the block.
module joystick_response_curve import jrc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [AXIS_W-1:0]     in_axis_value,
  output logic                  out_valid,
  output logic [AXIS_W-1:0]     out_drive_value,
  output logic                  out_clamped,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t    cfg;
  logic    q_valid;
  sample_t q_item;

  jrc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  jrc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .axis_value (in_axis_value),
    .deadband   (cfg.deadband),
    .busy       (busy),
    .q_valid    (q_valid),
    .q_item     (q_item)
  );

  jrc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .cfg             (cfg),
    .out_valid       (out_valid),
    .out_drive_value (out_drive_value),
    .out_clamped     (out_clamped)
  );

endmodule

### rtl/jrc_checker.sv
// ----------------------------------------------------------------------------
// Joystick response curve checker
// Port-level assertions on latency, queue occupancy and saturation.
// ----------------------------------------------------------------------------
`include "joystick_response_curve_macros.svh"

module jrc_checker import jrc_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [AXIS_W-1:0] out_drive_value,
  input logic              out_clamped
);

  logic take;
  logic at_limit;

  assign take     = start && !busy;
  assign at_limit = (out_drive_value == OUT_MAX) || (out_drive_value == OUT_MIN);

  `JRC_ASSERT(a_result_follows, clk, rst_n, take |-> ##10 out_valid, "Missing result.")
  `JRC_ASSERT(a_result_has_source, clk, rst_n, out_valid |-> $past(take, 10), "Spurious result.")
  `JRC_ASSERT(a_clamp_at_limit, clk, rst_n, out_valid && out_clamped |-> at_limit, "Clamp off limit.")
  `JRC_ASSERT_NEVER(a_never_busy, clk, rst_n, busy, "Queue filled up.")

endmodule

bind joystick_response_curve jrc_checker u_jrc_checker (.*);

### sim/joystick_response_curve_tb.sv
// ----------------------------------------------------------------------------
// Joystick response curve testbench
// Drives axis samples through the command interface and programs the curve
// over the APB-style port between phases. Each accepted sample is scored
// against an in-bench model of the deadband, quartic and saturation, and
// each drive value and clamp flag is compared in order of arrival.
// ----------------------------------------------------------------------------
module joystick_response_curve_tb;
  import jrc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [AXIS_W-1:0]     in_axis_value = '0;
  logic                  out_valid;
  logic [AXIS_W-1:0]     out_drive_value;
  logic                  out_clamped;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  coef_t           crv_coef [5];
  logic [DB_W-1:0] dead_zone;

  logic [AXIS_W-1:0] axis_q [$];
  logic [AXIS_W-1:0] curve_axis_q [$];
  logic [AXIS_W-1:0] curve_drive_q [$];
  logic              curve_clamp_q [$];

  int gap_pct = 25;
  int quiet_cycles = 0;
  int err_cnt = 0;
  int n_samples = 0;
  int n_dead = 0;
  int n_clamped = 0;
  int n_settings = 1;

  joystick_response_curve i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_axis_value   (in_axis_value),
    .out_valid       (out_valid),
    .out_drive_value (out_drive_value),
    .out_clamped     (out_clamped),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void shape_axis(input logic [AXIS_W-1:0] axis,
                                     output logic [AXIS_W-1:0] drive,
                                     output logic clamp, output logic dead);
    longint x;
    longint mag;
    longint acc;
    longint y;
    x = longint'(signed'(axis));
    mag = (x < 0) ? -x : x;
    drive = '0;
    clamp = 1'b0;
    dead = 1'b0;
    if (mag < longint'(dead_zone)) begin
      dead = 1'b1;
      return;
    end
    acc = longint'(crv_coef[0]);
    for (int i = 1; i < 5; i++) begin
      acc = ((acc * mag + 16384) >>> 15) + longint'(crv_coef[i]);
    end
    y = acc * 8;
    if (x < 0) begin
      y = -y;
    end
    if (y > 32767) begin
      y = 32767;
      clamp = 1'b1;
    end else if (y < -32768) begin
      y = -32768;
      clamp = 1'b1;
    end
    drive = y[AXIS_W-1:0];
  endfunction

  function automatic logic [AXIS_W-1:0] pick_axis();
    int sel;
    int v;
    sel = $urandom_range(99);
    if (sel < 10) begin
      case ($urandom_range(3))
        0: return 16'h8000;
        1: return 16'h7fff;
        2: return 16'h0000;
        default: return 16'h8001;
      endcase
    end else if (sel < 30) begin
      v = int'(dead_zone) + $urandom_range(6) - 3;
      if ($urandom_range(1) == 1) begin
        v = -v;
      end
      return 16'(v);
    end
    return 16'($urandom);
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_QUARTIC, REG_CUBIC, REG_SQUARE, REG_LINEAR, REG_OFFSET: crv_coef[idx] = val[15:0];
      REG_DEADBAND: dead_zone = val[DB_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_curve(input logic [15:0] a, input logic [15:0] b,
                               input logic [15:0] c, input logic [15:0] d,
                               input logic [15:0] e, input logic [DB_W-1:0] db);
    write_reg(REG_QUARTIC,  {16'($urandom), a});
    write_reg(REG_CUBIC,    {16'($urandom), b});
    write_reg(REG_SQUARE,   {16'($urandom), c});
    write_reg(REG_LINEAR,   {16'($urandom), d});
    write_reg(REG_OFFSET,   {16'($urandom), e});
    write_reg(REG_DEADBAND, {17'($urandom), db});
    n_settings++;
    @(negedge clk);
  endtask

  task automatic run_samples(input int n_random, input int gap);
    gap_pct = gap;
    repeat (n_random) axis_q.push_back(pick_axis());
    do @(negedge clk); while (axis_q.size() != 0 || start || curve_drive_q.size() != 0);
  endtask

  always @(posedge clk) begin : driver
    logic [AXIS_W-1:0] drive;
    logic              clamp;
    logic              dead;
    logic              take;
    if (!rst_n) begin
      start         <= 1'b0;
      in_axis_value <= '0;
    end else begin
      take = start && !busy;
      if (take) begin
        shape_axis(in_axis_value, drive, clamp, dead);
        curve_axis_q.push_back(in_axis_value);
        curve_drive_q.push_back(drive);
        curve_clamp_q.push_back(clamp);
        if (dead) begin
          n_dead++;
        end
      end
      if (take || !start) begin
        if (axis_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
          start         <= 1'b1;
          in_axis_value <= axis_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    logic [AXIS_W-1:0] axis;
    logic [AXIS_W-1:0] drive;
    logic              clamp;
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else begin
      if ((start && !busy) || out_valid) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_valid) begin
        n_samples++;
        if (out_clamped === 1'b1) begin
          n_clamped++;
        end
        if (curve_drive_q.size() == 0) begin
          if (err_cnt < MAX_REPORTS) begin
            $display("ERROR: unexpected transaction drive=%h clamped=%b",
                     out_drive_value, out_clamped);
          end
          err_cnt++;
        end else begin
          axis  = curve_axis_q.pop_front();
          drive = curve_drive_q.pop_front();
          clamp = curve_clamp_q.pop_front();
          if (out_drive_value !== drive || out_clamped !== clamp) begin
            if (err_cnt < MAX_REPORTS) begin
              $display("ERROR: axis=%h expected drive=%h clamped=%b, got drive=%h clamped=%b",
                       axis, drive, clamp, out_drive_value, out_clamped);
            end
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    wait (rst_n);
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("ERROR: no transaction for %0d cycles", STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    crv_coef[0] = RST_QUARTIC;
    crv_coef[1] = RST_CUBIC;
    crv_coef[2] = RST_SQUARE;
    crv_coef[3] = RST_LINEAR;
    crv_coef[4] = RST_OFFSET;
    dead_zone   = RST_DEADBAND;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    axis_q = '{16'h0000, 16'h0001, 16'hffff, 16'd327, 16'd328, 16'd329,
               16'(-327), 16'(-328), 16'h4000, 16'hc000, 16'h7fff, 16'h8001,
               16'h8000, 16'h2000, 16'he000, 16'h6000, 16'd1000, 16'(-1000)};
    run_samples(0, 25);
    run_samples(120, 0);

    program_curve(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 15'd0);
    axis_q = '{16'h0000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff};
    run_samples(60, 25);

    program_curve(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 15'h7fff);
    axis_q = '{16'h7fff, 16'h8000, 16'h8001, 16'h7ffe, 16'h8002, 16'h0000};
    run_samples(60, 25);

    program_curve(16'h0000, 16'h0000, 16'h0000, 16'h1000, 16'h0000, 15'd0);
    axis_q = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h4000};
    run_samples(60, 25);

    for (int k = 0; k < 5; k++) begin
      if (k < 2) begin
        program_curve(16'($signed($urandom_range(16383)) - 8192),
                      16'($signed($urandom_range(16383)) - 8192),
                      16'($signed($urandom_range(16383)) - 8192),
                      16'($signed($urandom_range(16383)) - 8192),
                      16'($signed($urandom_range(8191)) - 4096),
                      15'($urandom_range(2000)));
      end else begin
        program_curve(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), (k == 4) ? 15'($urandom) : 15'($urandom_range(4000)));
      end
      run_samples(85, 25);
    end

    repeat (20) @(posedge clk);
    @(negedge clk);
    $display("Checked %0d samples over %0d curve settings: %0d inside deadband, %0d clamped.",
             n_samples, n_settings, n_dead, n_clamped);
    $display("Mismatches: %0d, outstanding expectations: %0d.", err_cnt, curve_drive_q.size());
    if (err_cnt == 0 && curve_drive_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
